// ===== design/prld_pkg.sv =====
// Shared types and constants for the pair run-length decoder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package prld_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 2 * BYTE_W;
   localparam int LIMIT_W = 15;
   localparam int COUNT_W = WORD_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20960);

   typedef enum logic [2:0] {
      PH_HDR_HI  = 3'd0,
      PH_HDR_LO  = 3'd1,
      PH_LITERAL = 3'd2,
      PH_PAIR_A  = 3'd3,
      PH_PAIR_B  = 3'd4
   } phase_type;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] in_byte;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic              run_pending;
      logic              overrun_error;
   } result_type;

   // Flow control between the input stage and the result stage.
   typedef struct packed {
      logic item_valid;
      logic advance;
   } flow_type;

endpackage

`default_nettype wire

// ===== design/prld_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on prld_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface prld_req_if
   import prld_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output cmd, output in_byte, input ready);
   modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface prld_rsp_if
   import prld_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_valid;
   logic              run_pending;
   logic              overrun_error;

   modport source (output valid, output out_byte, output out_valid,
                   output run_pending, output overrun_error, input ready);
   modport sink   (input valid, input out_byte, input out_valid,
                   input run_pending, input overrun_error, output ready);
endinterface

`default_nettype wire

// ===== design/prld_in_stage.sv =====
// Input register of the decoder: captures one request transfer per cycle while it is empty or its item advances.
// Depends on prld_pkg and prld_req_if.
`timescale 1ns / 1ps
`default_nettype none

module prld_in_stage
   import prld_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   prld_req_if.sink    req_ch,
   input  wire logic   advance,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in        = 1'b1;
         item_in.cmd     = req_ch.cmd;
         item_in.in_byte = req_ch.in_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== design/prld_core.sv =====
// Decoder state and the single-pass update logic for one item.
// Depends on prld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prld_core
   import prld_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire item_type           item,
   input  wire logic [LIMIT_W-1:0] chunk_limit,
   output result_type              result
);

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  header_high_ff, header_high_in;
   logic [COUNT_W-1:0] remaining_ff, remaining_in;
   logic [BYTE_W-1:0]  pair_first_ff, pair_first_in;
   logic [BYTE_W-1:0]  pair_second_ff, pair_second_in;
   logic               next_is_first_ff, next_is_first_in;
   logic               repeating_ff, repeating_in;

   logic               run_active;
   logic [WORD_W-1:0]  word;
   logic [WORD_W-1:0]  mag;
   logic [COUNT_W-1:0] rem_dec;
   logic [COUNT_W-1:0] pair_total;

   assign run_active = repeating_ff && (remaining_ff != '0);
   assign word       = {header_high_ff, item.in_byte};
   assign mag        = word[WORD_W-1] ? (~word + WORD_W'(1)) : word;
   assign rem_dec    = remaining_ff - COUNT_W'(1);
   assign pair_total = {remaining_ff[COUNT_W-2:0], 1'b0} - COUNT_W'(1);

   always_comb begin
      phase_in         = phase_ff;
      header_high_in   = header_high_ff;
      remaining_in     = remaining_ff;
      pair_first_in    = pair_first_ff;
      pair_second_in   = pair_second_ff;
      next_is_first_in = next_is_first_ff;
      repeating_in     = repeating_ff;
      result           = '0;

      if (item.cmd == CMD_DRAIN) begin
         if (run_active) begin
            result.out_byte  = next_is_first_ff ? pair_first_ff : pair_second_ff;
            result.out_valid = 1'b1;
            next_is_first_in = !next_is_first_ff;
            remaining_in     = rem_dec;
            if (rem_dec == '0) begin
               repeating_in = 1'b0;
            end
         end
      end else if (run_active) begin
         result.overrun_error = 1'b1;
      end else begin
         case (phase_ff)
            PH_HDR_HI: begin
               header_high_in = item.in_byte;
               phase_in       = PH_HDR_LO;
            end
            PH_HDR_LO: begin
               if (word == '0 || mag >= {1'b0, chunk_limit}) begin
                  phase_in = PH_HDR_HI;
               end else if (word[WORD_W-1]) begin
                  remaining_in = mag;
                  phase_in     = PH_PAIR_A;
               end else begin
                  remaining_in = {mag[WORD_W-2:0], 1'b0};
                  repeating_in = 1'b0;
                  phase_in     = PH_LITERAL;
               end
            end
            PH_LITERAL: begin
               result.out_byte  = item.in_byte;
               result.out_valid = 1'b1;
               remaining_in     = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_HDR_HI;
               end
            end
            PH_PAIR_A: begin
               pair_first_in = item.in_byte;
               phase_in      = PH_PAIR_B;
            end
            PH_PAIR_B: begin
               pair_second_in   = item.in_byte;
               result.out_byte  = pair_first_ff;
               result.out_valid = 1'b1;
               remaining_in     = pair_total;
               next_is_first_in = 1'b0;
               repeating_in     = (pair_total != '0);
               phase_in         = PH_HDR_HI;
            end
            default: begin
               phase_in = PH_HDR_HI;
            end
         endcase
      end

      result.run_pending = repeating_in && (remaining_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HDR_HI;
         header_high_ff   <= '0;
         remaining_ff     <= '0;
         pair_first_ff    <= '0;
         pair_second_ff   <= '0;
         next_is_first_ff <= 1'b1;
         repeating_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         header_high_ff   <= header_high_in;
         remaining_ff     <= remaining_in;
         pair_first_ff    <= pair_first_in;
         pair_second_ff   <= pair_second_in;
         next_is_first_ff <= next_is_first_in;
         repeating_ff     <= repeating_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/prld_out_stage.sv =====
// Result register of the decoder: holds one result until the sink takes it.
// Depends on prld_pkg and prld_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module prld_out_stage
   import prld_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire result_type result,
   output flow_type        flow,
   prld_rsp_if.source      rsp_ch
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;
   logic       advance;

   // Take a new result when the register is empty or being emptied now.
   assign advance         = item_valid && (!valid_ff || rsp_ch.ready);
   assign flow.item_valid = item_valid;
   assign flow.advance    = advance;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (advance) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.out_byte      = result_ff.out_byte;
   assign rsp_ch.out_valid     = result_ff.out_valid;
   assign rsp_ch.run_pending   = result_ff.run_pending;
   assign rsp_ch.overrun_error = result_ff.overrun_error;

endmodule

`default_nettype wire

// ===== design/pair_run_length_decoder.sv =====
// Pair run-length decoder, top level: input register, decode core, result register.
// Path: a request is registered in the input register, decoded by the core and registered in the result register.
// Throughput: one item per cycle while the sink takes results; the decode state updates in one pass per item.
// Reset (synchronous, active high): both stages empty, decode state back to
// header-high phase, chunk_limit back to 20960.
// Depends on prld_pkg, prld_if, prld_in_stage, prld_core, prld_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module pair_run_length_decoder
   import prld_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   prld_req_if.sink                req_ch,
   prld_rsp_if.source              rsp_ch,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data
);

   logic [LIMIT_W-1:0] chunk_limit_ff, chunk_limit_in;
   logic               item_valid;
   item_type           item;
   result_type         result;
   flow_type           flow;

   // Chunk limit register: hold unless software writes it.
   assign chunk_limit_in = csr_wr_en ? csr_wr_data : chunk_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_limit_ff <= LIMIT_RESET;
      end else begin
         chunk_limit_ff <= chunk_limit_in;
      end
   end

   // Input register: refills in the same cycle that its item advances.
   prld_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (flow.advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Decode core: state advances only when the item moves into the result register.
   prld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (flow.advance),
      .item        (item),
      .chunk_limit (chunk_limit_ff),
      .result      (result)
   );

   // Result register: a waiting result that the sink has not taken stalls the core and the input register.
   prld_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .flow       (flow),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
